### hw/rtl/tgd_pkg.sv
// shared types, codes and name tables of the teleinfo group decoder
`timescale 1ns / 1ps

package tgd_pkg;

	localparam int CHAR_W    = 7;
	localparam int COUNT_W   = 6;
	localparam int VALUE_W   = 32;
	localparam int OPQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CH_LF    = 7'h0a;
	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
	localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
	localparam logic [7:0]        CHK_BIAS = 8'h20;
	localparam logic [5:0]        SUM_MASK = 6'h3f;
	localparam logic [COUNT_W-1:0] MIN_COUNT = 6'd9;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	localparam logic [1:0] KIND_BASE  = 2'd0;
	localparam logic [1:0] KIND_IINST = 2'd1;
	localparam logic [1:0] KIND_PAPP  = 2'd2;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_CONSUME = 2'd1,
		OP_FINISH  = 2'd2
	} op_code_t;

	typedef struct packed {
		op_code_t          code;
		logic [CHAR_W-1:0] data;
		logic              short_grp;
	} op_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         kind;
		logic [VALUE_W-1:0] value;
		logic               changed;
	} result_t;

	function automatic logic [2:0] name_len(input logic [1:0] k);
		case (k)
			2'd0: name_len = 3'd4;
			2'd1: name_len = 3'd5;
			2'd2: name_len = 3'd4;
			default: name_len = 3'd0;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] name_chr(input logic [1:0] k, input logic [2:0] pos);
		logic [CHAR_W-1:0] c;
		c = CH_NUL;
		case (k)
			2'd0: begin
				case (pos)
					3'd0: c = 7'h42;
					3'd1: c = 7'h41;
					3'd2: c = 7'h53;
					3'd3: c = 7'h45;
					default: c = CH_NUL;
				endcase
			end
			2'd1: begin
				case (pos)
					3'd0: c = 7'h49;
					3'd1: c = 7'h49;
					3'd2: c = 7'h4e;
					3'd3: c = 7'h53;
					3'd4: c = 7'h54;
					default: c = CH_NUL;
				endcase
			end
			2'd2: begin
				case (pos)
					3'd0: c = 7'h50;
					3'd1: c = 7'h41;
					3'd2: c = 7'h50;
					3'd3: c = 7'h50;
					default: c = CH_NUL;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/tgd_fifo.sv
// small register queue with show-ahead read
`timescale 1ns / 1ps

module tgd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/tgd_front.sv
// byte framing front end: group detection, count and two-byte delay line
`timescale 1ns / 1ps

module tgd_front
	import tgd_pkg::*;
#(
	parameter int BUF_SIZE = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] rx_byte,
	output logic       op_valid,
	output op_t        op
);

	logic                receiving_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CHAR_W-1:0]   dly0_q;
	logic [CHAR_W-1:0]   dly1_q;
	logic [CHAR_W-1:0]   c;
	logic [COUNT_W-1:0]  count_inc;

	assign c         = rx_byte[CHAR_W-1:0];
	assign count_inc = count_q + 1'b1;

	always_comb begin
		op_valid     = 1'b0;
		op.code      = OP_CONSUME;
		op.data      = dly0_q;
		op.short_grp = 1'b0;
		if (in_take) begin
			if (!receiving_q) begin
				if (c == CH_LF) begin
					op_valid = 1'b1;
					op.code  = OP_START;
				end
			end else if (c == CH_CR) begin
				op_valid     = 1'b1;
				op.code      = OP_FINISH;
				op.data      = dly1_q;
				op.short_grp = (count_q < MIN_COUNT);
			end else begin
				op_valid = (count_q >= COUNT_W'(2));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			count_q     <= '0;
			dly0_q      <= '0;
			dly1_q      <= '0;
		end else if (in_take) begin
			if (!receiving_q) begin
				if (c == CH_LF) begin
					receiving_q <= 1'b1;
					count_q     <= '0;
					dly0_q      <= '0;
					dly1_q      <= '0;
				end
			end else if (c == CH_CR) begin
				receiving_q <= 1'b0;
			end else begin
				dly0_q  <= dly1_q;
				dly1_q  <= c;
				count_q <= count_inc;
				if (count_inc >= COUNT_W'(BUF_SIZE - 1)) begin
					receiving_q <= 1'b0;
				end
			end
		end
	end

endmodule

### hw/rtl/tgd_back.sv
// back end: checksum, tokenizer, label match, value parse and stored values
`timescale 1ns / 1ps

module tgd_back
	import tgd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    op_avail,
	input  op_t     op,
	output logic    op_take,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	typedef enum logic [3:0] {
		PH_PRE_LABEL = 4'b0001,
		PH_LABEL     = 4'b0010,
		PH_PRE_VALUE = 4'b0100,
		PH_VALUE     = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [5:0]          sum_q, sum_n;
	logic [2:0]          alive_q, alive_n;
	logic [2:0]          pos_q, pos_n;
	logic [VALUE_W-1:0]  acc_q, acc_n;
	logic                neg_q, neg_n;
	logic                done_q, done_n;
	logic                ended_q, ended_n;
	logic [31:0]         stored_index_q;
	logic [7:0]          stored_current_q;
	logic [15:0]         stored_power_q;

	logic [CHAR_W-1:0]   c;
	logic                is_sep;
	logic                is_digit;
	logic [2:0]          alive_match;
	logic [2:0]          alive_len;
	logic [2:0]          alive_fin;
	logic [VALUE_W-1:0]  acc_step;
	logic [VALUE_W-1:0]  v;
	logic                chk_ok;

	assign c        = op.data;
	assign is_sep   = (c == CH_SPACE) || (c == CH_TAB);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign acc_step = (acc_q << 3) + (acc_q << 1) + VALUE_W'(c - CH_ZERO);
	assign op_take  = op_avail && ((op.code != OP_FINISH) || !res_full);
	assign res_push = op_take && (op.code == OP_FINISH);
	assign v        = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;
	assign chk_ok   = ((8'(sum_q) + CHK_BIAS) == 8'(op.data));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			alive_match[k] = alive_q[k] && (pos_q < name_len(2'(k)))
				&& (name_chr(2'(k), pos_q) == c);
			alive_len[k]   = alive_q[k] && (name_len(2'(k)) == pos_q);
		end
	end

	always_comb begin
		case (phase_q)
			PH_PRE_LABEL: alive_fin = 3'b000;
			PH_LABEL:     alive_fin = alive_len;
			default:      alive_fin = alive_q;
		endcase
	end

	// per-op state update
	always_comb begin
		phase_n = phase_q;
		sum_n   = sum_q;
		alive_n = alive_q;
		pos_n   = pos_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		done_n  = done_q;
		ended_n = ended_q;
		case (op.code)
			OP_START: begin
				phase_n = PH_PRE_LABEL;
				sum_n   = '0;
				alive_n = 3'b111;
				pos_n   = '0;
				acc_n   = '0;
				neg_n   = 1'b0;
				done_n  = 1'b0;
				ended_n = 1'b0;
			end
			OP_CONSUME: begin
				sum_n = (sum_q + c[5:0]) & SUM_MASK;
				if (!ended_q) begin
					if (c == CH_NUL) begin
						ended_n = 1'b1;
					end else begin
						case (phase_q)
							PH_PRE_LABEL: begin
								if (!is_sep) begin
									phase_n = PH_LABEL;
									alive_n = alive_match;
									pos_n   = (pos_q < 3'd7) ? pos_q + 1'b1 : pos_q;
								end
							end
							PH_LABEL: begin
								if (is_sep) begin
									alive_n = alive_len;
									phase_n = PH_PRE_VALUE;
								end else begin
									alive_n = alive_match;
									pos_n   = (pos_q < 3'd7) ? pos_q + 1'b1 : pos_q;
								end
							end
							PH_PRE_VALUE: begin
								if (!is_sep) begin
									phase_n = PH_VALUE;
									if (c == CH_MINUS) begin
										neg_n = 1'b1;
									end else if (c != CH_PLUS) begin
										if (is_digit) begin
											acc_n = acc_step;
										end else begin
											done_n = 1'b1;
										end
									end
								end
							end
							default: begin
								if (is_sep || done_q || !is_digit) begin
									done_n = 1'b1;
								end else begin
									acc_n = acc_step;
								end
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.status  = ST_ACCEPTED;
		res.kind    = KIND_BASE;
		res.value   = '0;
		res.changed = 1'b0;
		if (op.short_grp) begin
			res.status = ST_SHORT;
		end else if (!chk_ok) begin
			res.status = ST_CHECKSUM;
		end else if (alive_fin[0]) begin
			res.kind    = KIND_BASE;
			res.value   = v;
			res.changed = (stored_index_q != v);
		end else if (alive_fin[1]) begin
			res.kind    = KIND_IINST;
			res.value   = VALUE_W'(v[7:0]);
			res.changed = (stored_current_q != v[7:0]);
		end else if (alive_fin[2]) begin
			res.kind    = KIND_PAPP;
			res.value   = VALUE_W'(v[15:0]);
			res.changed = (stored_power_q != v[15:0]);
		end else begin
			res.status = ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_PRE_LABEL;
			sum_q            <= '0;
			alive_q          <= 3'b111;
			pos_q            <= '0;
			acc_q            <= '0;
			neg_q            <= 1'b0;
			done_q           <= 1'b0;
			ended_q          <= 1'b0;
			stored_index_q   <= '0;
			stored_current_q <= '0;
			stored_power_q   <= '0;
		end else if (op_take) begin
			phase_q <= phase_n;
			sum_q   <= sum_n;
			alive_q <= alive_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			done_q  <= done_n;
			ended_q <= ended_n;
			if (res_push && (res.status == ST_ACCEPTED)) begin
				case (res.kind)
					KIND_BASE:  stored_index_q   <= v;
					KIND_IINST: stored_current_q <= v[7:0];
					KIND_PAPP:  stored_power_q   <= v[15:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

### hw/rtl/teleinfo_group_decoder_unit.sv
// top level of the teleinfo group decoder
//
// Input channel: rx_byte with push/full; a transfer happens when push is
// high and full is low. Bit 7 of each byte is ignored.
// Result channel: status, group_kind, value, changed with empty/pop; the
// oldest result is shown while empty is low and leaves on pop.
// One result is produced for each CR that closes a group; other bytes
// produce none.
// Throughput: one byte per cycle while full is low. The framing front
// end feeds a four-entry op queue; the decode back end retires one op
// a cycle unless a CR op waits on a full result queue. Each result
// passes the op queue and the back end into the two-entry result queue.
// When the receiver stops popping, the result queue fills, the back end
// holds its CR op, the op queue fills and full rises; bytes other than
// CR keep flowing until then.
// Reset clears framing, tokenizer state, queues and the stored values.
`timescale 1ns / 1ps

module teleinfo_group_decoder_unit
	import tgd_pkg::*;
#(
	parameter int BUF_SIZE = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [1:0]  group_kind,
	output logic [31:0] value,
	output logic        changed
);

	logic    in_take;
	logic    fop_valid;
	op_t     fop;
	op_t     qop;
	logic    qop_empty;
	logic    qop_take;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_out;

	assign in_take = push && !full;

	tgd_front #(
		.BUF_SIZE(BUF_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.rx_byte  (rx_byte),
		.op_valid (fop_valid),
		.op       (fop)
	);

	tgd_fifo #(
		.WIDTH($bits(op_t)),
		.DEPTH(OPQ_DEPTH)
	) u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fop_valid),
		.wr_data (fop),
		.full    (full),
		.rd_en   (qop_take),
		.rd_data (qop),
		.empty   (qop_empty)
	);

	tgd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_avail (!qop_empty),
		.op       (qop),
		.op_take  (qop_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	tgd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign status     = res_out.status;
	assign group_kind = res_out.kind;
	assign value      = res_out.value;
	assign changed    = res_out.changed;

endmodule

### sim/tgd_result_checker.sv
// result checker for the teleinfo group decoder: parses the byte stream and compares each result
`timescale 1ns / 1ps

module tgd_result_checker
	import tgd_pkg::*;
#(
	parameter int BUF_SIZE = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [1:0]  group_kind,
	input  logic [31:0] value,
	input  logic        changed,
	output int          fail_count,
	output int          pending
);

	typedef enum logic [1:0] {
		TK_LEAD,
		TK_LABEL,
		TK_GAP,
		TK_NUMBER
	} token_state_t;

	logic               in_group;
	logic [COUNT_W-1:0] char_cnt;
	logic [5:0]         chk_sum;
	logic [CHAR_W-1:0]  held_old;
	logic [CHAR_W-1:0]  held_new;
	token_state_t       tok;
	logic [CHAR_W-1:0]  label_q[$];
	logic [31:0]        number;
	logic               minus;
	logic               number_done;
	logic               text_end;
	logic [31:0]        base_index;
	logic [7:0]         inst_current;
	logic [15:0]        app_power;
	result_t            decoded_q[$];

	function automatic bit is_blank(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit label_is(input string name);
		byte ch;
		if (label_q.size() != name.len())
			return 1'b0;
		for (int i = 0; i < name.len(); i++) begin
			ch = name[i];
			if (label_q[i] != ch[CHAR_W-1:0])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic start_group;
		char_cnt = '0;
		chk_sum = '0;
		held_old = '0;
		held_new = '0;
		tok = TK_LEAD;
		label_q.delete();
		number = '0;
		minus = 1'b0;
		number_done = 1'b0;
		text_end = 1'b0;
	endtask

	task automatic add_digit(input logic [CHAR_W-1:0] c);
		if (!number_done && c >= CH_ZERO && c <= CH_NINE) begin
			number = number * 32'd10 + 32'(c - CH_ZERO);
		end else begin
			number_done = 1'b1;
		end
	endtask

	// a byte leaving the two-deep delay line
	task automatic tokenize(input logic [CHAR_W-1:0] c);
		chk_sum = chk_sum + c[5:0];
		if (text_end)
			return;
		if (c == CH_NUL) begin
			text_end = 1'b1;
			return;
		end
		case (tok)
			TK_LEAD: begin
				if (!is_blank(c)) begin
					tok = TK_LABEL;
					label_q.push_back(c);
				end
			end
			TK_LABEL: begin
				if (is_blank(c))
					tok = TK_GAP;
				else
					label_q.push_back(c);
			end
			TK_GAP: begin
				if (!is_blank(c)) begin
					tok = TK_NUMBER;
					if (c == CH_MINUS)
						minus = 1'b1;
					else if (c != CH_PLUS)
						add_digit(c);
				end
			end
			default: begin
				if (is_blank(c))
					number_done = 1'b1;
				else
					add_digit(c);
			end
		endcase
	endtask

	task automatic close_group;
		result_t r;
		logic [31:0] v;
		r = '0;
		v = minus ? -number : number;
		if (char_cnt < MIN_COUNT) begin
			r.status = ST_SHORT;
		end else if (8'(chk_sum) + CHK_BIAS != {1'b0, held_new}) begin
			r.status = ST_CHECKSUM;
		end else if (label_is("BASE")) begin
			r.kind = KIND_BASE;
			r.value = v;
			r.changed = base_index != v;
			base_index = v;
		end else if (label_is("IINST")) begin
			r.kind = KIND_IINST;
			r.value = {24'd0, v[7:0]};
			r.changed = inst_current != v[7:0];
			inst_current = v[7:0];
		end else if (label_is("PAPP")) begin
			r.kind = KIND_PAPP;
			r.value = {16'd0, v[15:0]};
			r.changed = app_power != v[15:0];
			app_power = v[15:0];
		end else begin
			r.status = ST_UNKNOWN;
		end
		decoded_q.push_back(r);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [CHAR_W-1:0] c;
		c = b[CHAR_W-1:0];
		if (!in_group) begin
			if (c == CH_LF) begin
				start_group();
				in_group = 1'b1;
			end
		end else if (c == CH_CR) begin
			in_group = 1'b0;
			close_group();
		end else begin
			if (char_cnt >= 2)
				tokenize(held_old);
			held_old = held_new;
			held_new = c;
			char_cnt = char_cnt + 1'b1;
			// overrun drops the group silently
			if (int'(char_cnt) >= BUF_SIZE - 1)
				in_group = 1'b0;
		end
	endtask

	task automatic check_result;
		result_t want;
		bit bad;
		bad = 1'b0;
		if (decoded_q.size() == 0) begin
			$error("result with none expected: status %0d kind %0d value %0h changed %0b",
				status, group_kind, value, changed);
			fail_count++;
			return;
		end
		want = decoded_q.pop_front();
		if (status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, status);
			bad = 1'b1;
		end
		if (group_kind !== want.kind) begin
			$error("group_kind: expected %0d, actual %0d", want.kind, group_kind);
			bad = 1'b1;
		end
		if (value !== want.value) begin
			$error("value: expected %0h, actual %0h", want.value, value);
			bad = 1'b1;
		end
		if (changed !== want.changed) begin
			$error("changed: expected %0b, actual %0b", want.changed, changed);
			bad = 1'b1;
		end
		if (bad)
			fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_group = 1'b0;
			start_group();
			base_index = '0;
			inst_current = '0;
			app_power = '0;
			decoded_q.delete();
			fail_count = 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				decode_byte(rx_byte);
		end
		pending = decoded_q.size();
	end

endmodule

### sim/tb_top.sv
// testbench top: sends meter byte groups to the decoder, pops results and gives the verdict
`timescale 1ns / 1ps

module tb_top;
	import tgd_pkg::*;

	localparam int BUF_SIZE    = 21;
	localparam int ITEMS       = 1650;
	localparam int STUCK_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        rx_byte = 8'h00;
	logic              empty;
	logic              pop = 1'b0;
	logic [1:0]        status;
	logic [1:0]        group_kind;
	logic [31:0]       value;
	logic              changed;
	int                fail_count;
	int                pending;
	int                sent = 0;
	int                send_idle = 0;
	int                recv_stall = 0;
	int                stuck = 0;
	logic [CHAR_W-1:0] body_q[$];
	string             labels[3] = '{"BASE", "IINST", "PAPP"};
	string             label_pool = "ABEINPSTbx";
	int                idle_plan[4] = '{0, 83, 0, 7};
	int                stall_plan[4] = '{0, 0, 83, 7};

	always #5 clk = ~clk;

	teleinfo_group_decoder_unit #(
		.BUF_SIZE(BUF_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.status(status),
		.group_kind(group_kind),
		.value(value),
		.changed(changed)
	);

	tgd_result_checker #(
		.BUF_SIZE(BUF_SIZE)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.status(status),
		.group_kind(group_kind),
		.value(value),
		.changed(changed),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic logic [7:0] with_parity(input logic [CHAR_W-1:0] c);
		return {1'($urandom_range(0, 1)), c};
	endfunction

	function automatic logic [CHAR_W-1:0] blank();
		return ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE;
	endfunction

	function automatic logic [CHAR_W-1:0] printable();
		return 7'($urandom_range(32, 126));
	endfunction

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			@(negedge clk);
			push <= 1'b0;
			rx_byte <= 8'($urandom);
		end
		@(negedge clk);
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
	endtask

	task automatic add_text(input string s);
		byte ch;
		for (int i = 0; i < s.len(); i++) begin
			ch = s[i];
			body_q.push_back(ch[CHAR_W-1:0]);
		end
	endtask

	task automatic add_digits(input int n);
		repeat (n) body_q.push_back(CH_ZERO + 7'($urandom_range(0, 9)));
	endtask

	// frames the body: LF, body, separator, checksum, CR
	task automatic send_group(input bit bad_chk);
		logic [5:0] chk_sum;
		logic [CHAR_W-1:0] chk;
		chk_sum = '0;
		foreach (body_q[i]) chk_sum += body_q[i][5:0];
		chk = {1'b0, chk_sum} + 7'(CHK_BIAS);
		if (bad_chk)
			chk ^= 7'(1 << $urandom_range(0, 5));
		sent += body_q.size() + 4;
		put_byte(with_parity(CH_LF));
		foreach (body_q[i]) put_byte(with_parity(body_q[i]));
		put_byte(with_parity(blank()));
		put_byte(with_parity(chk));
		put_byte(with_parity(CH_CR));
		body_q.delete();
	endtask

	initial begin
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				stuck = 0;
			else
				stuck++;
		end
		$display("teleinfo_group_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		int r;
		int room;
		int k;
		byte ch;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray bytes while idle, then CR right after LF
		put_byte(with_parity(CH_CR));
		put_byte(with_parity(7'h41));
		put_byte(with_parity(CH_LF));
		put_byte(with_parity(CH_CR));
		sent += 4;
		add_text("BASE");
		body_q.push_back(blank());
		add_text("4294967295");
		send_group(1'b0);
		add_text("BASE 4294967295");
		send_group(1'b0);
		add_text("IINST -1");
		send_group(1'b0);
		add_text("PAPP\t+65535");
		send_group(1'b0);
		add_text("PAPP 65536");
		send_group(1'b0);
		add_text("BASE 000123");
		send_group(1'b1);
		add_text("BASEX 12");
		send_group(1'b0);
		add_text("  IINST 7");
		send_group(1'b0);
		// empty value token
		add_text("IINST  ");
		send_group(1'b0);
		// one byte short of the minimum, then exactly the minimum
		add_text("PAPP 1");
		send_group(1'b0);
		add_text("PAPP 12");
		send_group(1'b0);
		add_text("BASE 12");
		body_q.push_back(CH_NUL);
		add_text("34");
		send_group(1'b0);
		add_text("PAPP 3");
		body_q.push_back(CH_LF);
		add_text("4");
		send_group(1'b0);
		add_text("BASE 12A34 9");
		send_group(1'b0);
		// longest group kept, then one that overruns
		add_text("BASE 123456789012");
		send_group(1'b0);
		add_text("BASE 1234567890123");
		send_group(1'b0);
		add_text("       ");
		send_group(1'b0);
		add_text("IINST\t-x9");
		send_group(1'b0);

		for (int step = 0; step < 16; step++) begin
			send_idle = idle_plan[step % 4];
			recv_stall = stall_plan[step % 4];
			while (sent < ITEMS * (step + 1) / 16) begin
				r = $urandom_range(0, 99);
				if (r < 68) begin
					if ($urandom_range(0, 9) == 0)
						body_q.push_back(blank());
					add_text(labels[$urandom_range(0, 2)]);
					body_q.push_back(blank());
					if ($urandom_range(0, 7) == 0)
						body_q.push_back(blank());
					k = $urandom_range(0, 9);
					if (k == 0)
						body_q.push_back(CH_MINUS);
					else if (k == 1)
						body_q.push_back(CH_PLUS);
					room = 17 - body_q.size();
					add_digits($urandom_range(0, room));
					if ($urandom_range(0, 9) == 0 && body_q.size() < 17)
						body_q.push_back(printable());
					if ($urandom_range(0, 15) == 0)
						body_q.insert($urandom_range(0, body_q.size() - 1),
							($urandom_range(0, 1) == 0) ? CH_NUL : CH_LF);
					send_group($urandom_range(0, 9) == 0);
				end else if (r < 80) begin
					// labels close to the real ones
					repeat ($urandom_range(1, 6)) begin
						ch = label_pool[$urandom_range(0, label_pool.len() - 1)];
						body_q.push_back(ch[CHAR_W-1:0]);
					end
					body_q.push_back(blank());
					add_digits($urandom_range(0, 8));
					send_group($urandom_range(0, 7) == 0);
				end else if (r < 88) begin
					repeat ($urandom_range(0, 7)) body_q.push_back(printable());
					send_group($urandom_range(0, 1) == 0);
				end else if (r < 93) begin
					repeat ($urandom_range(16, 24)) body_q.push_back(printable());
					send_group(1'b0);
				end else begin
					k = $urandom_range(1, 12);
					sent += k;
					repeat (k) put_byte(8'($urandom));
				end
			end
		end

		@(negedge clk);
		push <= 1'b0;
		recv_stall = 0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("teleinfo_group_decoder_unit: match");
		end else begin
			$display("teleinfo_group_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/tgd_pkg.sv
hw/rtl/tgd_fifo.sv
hw/rtl/tgd_front.sv
hw/rtl/tgd_back.sv
hw/rtl/teleinfo_group_decoder_unit.sv
sim/tgd_result_checker.sv
sim/tb_top.sv
